FILE: rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int QW = 16;
  localparam int DW = 17;
  localparam int QB = 17;
  localparam int Q_MAX = 32767;
  localparam logic [QB-1:0] Q_LIM = 17'd32768;

  typedef enum logic [1:0] {
    BEST_X = 2'd0,
    BEST_Y = 2'd1,
    BEST_Z = 2'd2,
    BEST_W = 2'd3
  } best_t;

  typedef struct packed {
    logic signed [QW-1:0] row1_col1;
    logic signed [QW-1:0] row1_col2;
    logic signed [QW-1:0] row1_col3;
    logic signed [QW-1:0] row2_col1;
    logic signed [QW-1:0] row2_col2;
    logic signed [QW-1:0] row2_col3;
    logic signed [QW-1:0] row3_col1;
    logic signed [QW-1:0] row3_col2;
    logic signed [QW-1:0] row3_col3;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
    logic                 conversion_ok;
  } out_t;

endpackage

FILE: rtl/rmq_sqrt.sv
module rmq_sqrt #(
  parameter int SW   = 23,
  parameter int SB_W = 54
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*SW-1:0]   in_x,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [SW-1:0]     out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int XW = 2 * SW;
  localparam int RMW = SW + 3;

  logic [XW-1:0]   s_x    [0:SW];
  logic [RMW-1:0]  s_rem  [0:SW];
  logic [SW-1:0]   s_root [0:SW];
  logic [SB_W-1:0] s_sb   [0:SW];
  logic            s_v    [0:SW];

  logic [XW-1:0]   x_r    [0:SW-1];
  logic [RMW-1:0]  rem_r  [0:SW-1];
  logic [SW-1:0]   root_r [0:SW-1];
  logic [SB_W-1:0] sb_r   [0:SW-1];
  logic            v_r    [0:SW-1];

  assign s_x[0]    = in_x;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_sb[0]   = in_sb;
  assign s_v[0]    = in_valid;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RMW-1:0] sh;
    logic [RMW-1:0] trial;
    logic           take;
    logic [XW-1:0]  x_nxt;
    logic [RMW-1:0] rem_nxt;
    logic [SW-1:0]  root_nxt;

    always_comb begin
      sh       = {s_rem[k][SW:0], s_x[k][XW-1:XW-2]};
      trial    = {1'b0, s_root[k], 2'b01};
      take     = (sh >= trial);
      x_nxt    = {s_x[k][XW-3:0], 2'b00};
      rem_nxt  = take ? (sh - trial) : sh;
      root_nxt = {s_root[k][SW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= s_v[k];
      end
      if (en) begin
        x_r[k]    <= x_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= s_sb[k];
      end
    end

    assign s_x[k+1]    = x_r[k];
    assign s_rem[k+1]  = rem_r[k];
    assign s_root[k+1] = root_r[k];
    assign s_sb[k+1]   = sb_r[k];
    assign s_v[k+1]    = v_r[k];
  end

  assign out_valid = s_v[SW];
  assign out_root  = s_root[SW];
  assign out_sb    = s_sb[SW];

endmodule

FILE: rtl/rmq_div.sv
module rmq_div #(
  parameter int NW   = 32,
  parameter int DNW  = 24,
  parameter int SB_W = 22
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][NW-1:0]     in_num,
  input  logic [DNW-1:0]         in_den,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_valid,
  output logic [2:0][rmq_pkg::QB-1:0] out_q,
  output logic [2:0]             out_ovf,
  output logic [SB_W-1:0]        out_sb
);
  import rmq_pkg::*;

  localparam int CW = ((NW > DNW + QB) ? NW : DNW + QB) + 1;

  logic [2:0][CW-1:0] s_rem [0:QB+1];
  logic [2:0][QB-1:0] s_q   [0:QB+1];
  logic [2:0]         s_ovf [0:QB+1];
  logic [DNW-1:0]     s_den [0:QB+1];
  logic [SB_W-1:0]    s_sb  [0:QB+1];
  logic               s_v   [0:QB+1];

  logic [2:0][CW-1:0] rem_r [0:QB];
  logic [2:0][QB-1:0] q_r   [0:QB];
  logic [2:0]         ovf_r [0:QB];
  logic [DNW-1:0]     den_r [0:QB];
  logic [SB_W-1:0]    sb_r  [0:QB];
  logic               v_r   [0:QB];

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign s_rem[0][l] = CW'(in_num[l]);
  end
  assign s_q[0]   = '0;
  assign s_ovf[0] = '0;
  assign s_den[0] = in_den;
  assign s_sb[0]  = in_sb;
  assign s_v[0]   = in_valid;

  for (genvar k = 0; k <= QB; k++) begin : g_stage
    logic [2:0][CW-1:0] rem_nxt;
    logic [2:0][QB-1:0] q_nxt;
    logic [2:0]         ovf_nxt;
    logic [CW-1:0]      t;

    if (k == 0) begin : g_ovf
      always_comb begin
        rem_nxt = s_rem[k];
        q_nxt   = s_q[k];
        t       = CW'(s_den[k]) << QB;
        for (int l = 0; l < 3; l++) begin
          ovf_nxt[l] = (s_rem[k][l] >= t);
        end
      end
    end else begin : g_bit
      always_comb begin
        rem_nxt = s_rem[k];
        q_nxt   = s_q[k];
        ovf_nxt = s_ovf[k];
        t       = CW'(s_den[k]) << (QB - k);
        for (int l = 0; l < 3; l++) begin
          if (s_rem[k][l] >= t) begin
            rem_nxt[l]       = s_rem[k][l] - t;
            q_nxt[l][QB - k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= s_v[k];
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_nxt;
        den_r[k] <= s_den[k];
        sb_r[k]  <= s_sb[k];
      end
    end

    assign s_rem[k+1] = rem_r[k];
    assign s_q[k+1]   = q_r[k];
    assign s_ovf[k+1] = ovf_r[k];
    assign s_den[k+1] = den_r[k];
    assign s_sb[k+1]  = sb_r[k];
    assign s_v[k+1]   = v_r[k];
  end

  assign out_valid = s_v[QB+1];
  assign out_q     = s_q[QB+1];
  assign out_ovf   = s_ovf[QB+1];
  assign out_sb    = s_sb[QB+1];

endmodule

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// Channel  Ports                        Direction  Beat
// in       in_valid/in_ready/in_data    input      one 3x3 matrix, Q2.14
// out      out_valid/out_ready/out_data output     one quaternion and ok flag
//
// Stages: sums, pick, square root (SW bits, 17 at FRAC_BITS 14), operands, divider, output.
// One matrix per cycle while the output is not stalled; depth is set by the bit-per-stage square root and divider.
// Synchronous active-low reset clears all valid bits; no data reset.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rmq_pkg::out_t out_data
);
  import rmq_pkg::*;

  localparam int EW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int RW  = EW - 1 + FRAC_BITS;
  localparam int SW  = (RW + 1) / 2;
  localparam int XW  = 2 * SW;
  localparam int MW  = DW + FRAC_BITS;
  localparam int NW  = ((MW > SW) ? MW : SW) + 1;
  localparam int DNW = SW + 1;
  localparam int SB1 = 2 + 1 + 3 * DW;
  localparam int SB2 = 2 + 1 + QW + 3;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // diagonal sums and off-diagonal sums and differences
  logic signed [EW-1:0] e_r [0:3];
  logic signed [DW-1:0] s12_r, s13_r, d23_r, s23_r, d31_r, d12_r;
  logic                 v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      e_r[0] <= (EW'(1) <<< FRAC_BITS) + EW'(in_data.row1_col1)
                - EW'(in_data.row2_col2) - EW'(in_data.row3_col3);
      e_r[1] <= (EW'(1) <<< FRAC_BITS) - EW'(in_data.row1_col1)
                + EW'(in_data.row2_col2) - EW'(in_data.row3_col3);
      e_r[2] <= (EW'(1) <<< FRAC_BITS) - EW'(in_data.row1_col1)
                - EW'(in_data.row2_col2) + EW'(in_data.row3_col3);
      e_r[3] <= (EW'(1) <<< FRAC_BITS) + EW'(in_data.row1_col1)
                + EW'(in_data.row2_col2) + EW'(in_data.row3_col3);
      s12_r <= DW'(in_data.row1_col2) + DW'(in_data.row2_col1);
      s13_r <= DW'(in_data.row3_col1) + DW'(in_data.row1_col3);
      d23_r <= DW'(in_data.row2_col3) - DW'(in_data.row3_col2);
      s23_r <= DW'(in_data.row2_col3) + DW'(in_data.row3_col2);
      d31_r <= DW'(in_data.row3_col1) - DW'(in_data.row1_col3);
      d12_r <= DW'(in_data.row1_col2) - DW'(in_data.row2_col1);
    end
  end

  // pick largest sum, first wins ties
  best_t                best_nxt, best_r;
  logic signed [EW-1:0] emax;
  logic                 ok_nxt, ok_r;
  logic signed [DW-1:0] a_nxt, b_nxt, c_nxt, a_r, b_r, c_r;
  logic [XW-1:0]        x_nxt, x_r;
  logic                 v2_r;

  always_comb begin
    best_nxt = BEST_X;
    emax     = e_r[0];
    if (e_r[1] > emax) begin
      best_nxt = BEST_Y;
      emax     = e_r[1];
    end
    if (e_r[2] > emax) begin
      best_nxt = BEST_Z;
      emax     = e_r[2];
    end
    if (e_r[3] > emax) begin
      best_nxt = BEST_W;
      emax     = e_r[3];
    end
    ok_nxt = (emax > 0);
    x_nxt  = ok_nxt ? (XW'(emax[EW-2:0]) << FRAC_BITS) : '0;
    unique case (best_nxt)
      BEST_X: begin
        a_nxt = s12_r; b_nxt = s13_r; c_nxt = d23_r;
      end
      BEST_Y: begin
        a_nxt = s12_r; b_nxt = s23_r; c_nxt = d31_r;
      end
      BEST_Z: begin
        a_nxt = s13_r; b_nxt = s23_r; c_nxt = d12_r;
      end
      default: begin
        a_nxt = d23_r; b_nxt = d31_r; c_nxt = d12_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      best_r <= best_nxt;
      ok_r   <= ok_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      c_r    <= c_nxt;
      x_r    <= x_nxt;
    end
  end

  logic            sq_v;
  logic [SW-1:0]   sq_root;
  logic [SB1-1:0]  sq_sb;

  rmq_sqrt #(.SW(SW), .SB_W(SB1)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_x      (x_r),
    .in_sb     ({best_r, ok_r, a_r, b_r, c_r}),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // divider operands: |d| << FRAC_BITS plus half of 4v, over 4v
  logic signed [DW-1:0] sq_d [0:2];
  logic [2:0][NW-1:0]   num_nxt, num_r;
  logic [2:0]           neg_nxt;
  logic [DNW-1:0]       den_nxt, den_r;
  logic [QW-1:0]        vs_nxt;
  logic [SB2-1:0]       sb3_r;
  logic                 v3_r;

  assign sq_d[0] = sq_sb[3*DW-1:2*DW];
  assign sq_d[1] = sq_sb[2*DW-1:DW];
  assign sq_d[2] = sq_sb[DW-1:0];

  always_comb begin
    logic [DW-1:0] mag;
    den_nxt = {sq_root[SW-1:1], 2'b00};
    vs_nxt  = (sq_root[SW-1:1] > (SW-1)'(Q_MAX)) ? QW'(Q_MAX) : QW'(sq_root[SW-1:1]);
    for (int l = 0; l < 3; l++) begin
      neg_nxt[l] = sq_d[l][DW-1];
      mag        = neg_nxt[l] ? DW'(-sq_d[l]) : DW'(sq_d[l]);
      num_nxt[l] = (NW'(mag) << FRAC_BITS) + NW'({sq_root[SW-1:1], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_v;
    end
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      sb3_r <= {sq_sb[SB1-1:SB1-3], vs_nxt, neg_nxt};
    end
  end

  logic                 dv_v;
  logic [2:0][QB-1:0]   dv_q;
  logic [2:0]           dv_ovf;
  logic [SB2-1:0]       dv_sb;

  rmq_div #(.NW(NW), .DNW(DNW), .SB_W(SB2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_sb     (sb3_r),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_ovf   (dv_ovf),
    .out_sb    (dv_sb)
  );

  // saturate, place components, mask on failure
  best_t         f_best;
  logic          f_ok;
  logic [QW-1:0] f_v;
  logic [QW-1:0] comp [0:2];
  out_t          out_nxt, out_r;
  logic          out_valid_r;

  assign f_best = best_t'(dv_sb[SB2-1:SB2-2]);
  assign f_ok   = dv_sb[SB2-3];
  assign f_v    = dv_sb[QW+2:3];

  always_comb begin
    logic [QB-1:0] qv;
    for (int l = 0; l < 3; l++) begin
      qv = (dv_ovf[l] || dv_q[l] > Q_LIM) ? Q_LIM : dv_q[l];
      if (dv_sb[l]) begin
        comp[l] = QW'(-qv);
      end else begin
        comp[l] = (qv > QB'(Q_MAX)) ? QW'(Q_MAX) : QW'(qv);
      end
    end
    unique case (f_best)
      BEST_X: begin
        out_nxt.quat_x = f_v;     out_nxt.quat_y = comp[0];
        out_nxt.quat_z = comp[1]; out_nxt.quat_w = comp[2];
      end
      BEST_Y: begin
        out_nxt.quat_x = comp[0]; out_nxt.quat_y = f_v;
        out_nxt.quat_z = comp[1]; out_nxt.quat_w = comp[2];
      end
      BEST_Z: begin
        out_nxt.quat_x = comp[0]; out_nxt.quat_y = comp[1];
        out_nxt.quat_z = f_v;     out_nxt.quat_w = comp[2];
      end
      default: begin
        out_nxt.quat_x = comp[0]; out_nxt.quat_y = comp[1];
        out_nxt.quat_z = comp[2]; out_nxt.quat_w = f_v;
      end
    endcase
    out_nxt.conversion_ok = f_ok;
    if (!f_ok) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.conversion_ok |->
      out_data.quat_x == '0 && out_data.quat_y == '0 &&
      out_data.quat_z == '0 && out_data.quat_w == '0)
    else $error("failed conversion with nonzero components");

  a_ok_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.conversion_ok |->
      out_data.quat_x > 0 || out_data.quat_y > 0 ||
      out_data.quat_z > 0 || out_data.quat_w > 0)
    else $error("good conversion without a positive component");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: dv/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 45;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM = 1100;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  in_t  pending_mats[$];
  out_t expected_quats[$];
  int   errors;
  int   idle_cycles;
  bit   hold_sender;
  bit   in_taken;
  int   burst_left;
  int   gap_left;
  int   stall_phase;
  int   stall_period;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] offdiag_term(longint d, longint unsigned v);
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    den = v * 4;
    mag = longint'(d < 0 ? -d : d) << FRAC;
    q = (mag + den / 2) / den;
    if (q > 32768) q = 32768;
    return clamp16(d < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic out_t matrix_to_quat(in_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
    longint diag [4];
    longint unsigned v;
    best_t best;
    out_t r;
    a11 = m.row1_col1; a12 = m.row1_col2; a13 = m.row1_col3;
    a21 = m.row2_col1; a22 = m.row2_col2; a23 = m.row2_col3;
    a31 = m.row3_col1; a32 = m.row3_col2; a33 = m.row3_col3;
    diag[0] = (1 << FRAC) + a11 - a22 - a33;
    diag[1] = (1 << FRAC) - a11 + a22 - a33;
    diag[2] = (1 << FRAC) - a11 - a22 + a33;
    diag[3] = (1 << FRAC) + a11 + a22 + a33;
    best = BEST_X;
    for (int i = 1; i < 4; i++) if (diag[i] > diag[best]) best = best_t'(i);
    r = '0;
    if (diag[best] <= 0) return r;
    v = int_sqrt(longint'(diag[best]) << FRAC) >> 1;
    r.conversion_ok = 1'b1;
    case (best)
      BEST_X: begin
        r.quat_x = clamp16(v);
        r.quat_y = offdiag_term(a12 + a21, v);
        r.quat_z = offdiag_term(a31 + a13, v);
        r.quat_w = offdiag_term(a23 - a32, v);
      end
      BEST_Y: begin
        r.quat_y = clamp16(v);
        r.quat_x = offdiag_term(a12 + a21, v);
        r.quat_z = offdiag_term(a23 + a32, v);
        r.quat_w = offdiag_term(a31 - a13, v);
      end
      BEST_Z: begin
        r.quat_z = clamp16(v);
        r.quat_x = offdiag_term(a31 + a13, v);
        r.quat_y = offdiag_term(a23 + a32, v);
        r.quat_w = offdiag_term(a12 - a21, v);
      end
      default: begin
        r.quat_w = clamp16(v);
        r.quat_x = offdiag_term(a23 - a32, v);
        r.quat_y = offdiag_term(a31 - a13, v);
        r.quat_z = offdiag_term(a12 - a21, v);
      end
    endcase
    return r;
  endfunction

  function automatic in_t diag_mat(int d1, int d2, int d3, int off);
    in_t m;
    m = '0;
    m.row1_col1 = 16'(d1); m.row2_col2 = 16'(d2); m.row3_col3 = 16'(d3);
    m.row1_col2 = 16'(off); m.row2_col1 = 16'(-off);
    m.row2_col3 = 16'(off / 2); m.row3_col2 = 16'(off / 3);
    m.row1_col3 = 16'(-off); m.row3_col1 = 16'(off);
    return m;
  endfunction

  function automatic logic signed [15:0] near(int center, int spread);
    return 16'(center + $signed($urandom_range(2 * spread)) - spread);
  endfunction

  // rotation-like: one of four diagonal sign patterns, all entries spread by 2000 or 16384
  function automatic in_t rand_rotation_like();
    in_t m;
    int pick;
    int s;
    pick = $urandom_range(3);
    s = $urandom_range(1) ? 16384 : 2000;
    m.row1_col1 = near((pick == 0 || pick == 3) ? 16384 : -16384, s);
    m.row2_col2 = near((pick == 1 || pick == 3) ? 16384 : -16384, s);
    m.row3_col3 = near((pick == 2 || pick == 3) ? 16384 : -16384, s);
    m.row1_col2 = near(0, s); m.row1_col3 = near(0, s);
    m.row2_col1 = near(0, s); m.row2_col3 = near(0, s);
    m.row3_col1 = near(0, s); m.row3_col2 = near(0, s);
    return m;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % stall_period;
      out_ready <= (stall_phase < stall_period / 2) || (stall_period < 3);
      if (in_valid && !in_taken) begin
        // hold beat
      end else if (hold_sender || pending_mats.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_mats.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(8);
          stall_period <= $urandom_range(4) == 0 ? 1 : $urandom_range(9, 2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) expected_quats.push_back(matrix_to_quat(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          $error("unexpected beat %h", out_data);
          errors++;
        end else begin
          out_t e;
          e = expected_quats.pop_front();
          if (out_data.quat_x !== e.quat_x) begin
            $error("quat_x exp %0d got %0d", e.quat_x, out_data.quat_x);
            errors++;
          end
          if (out_data.quat_y !== e.quat_y) begin
            $error("quat_y exp %0d got %0d", e.quat_y, out_data.quat_y);
            errors++;
          end
          if (out_data.quat_z !== e.quat_z) begin
            $error("quat_z exp %0d got %0d", e.quat_z, out_data.quat_z);
            errors++;
          end
          if (out_data.quat_w !== e.quat_w) begin
            $error("quat_w exp %0d got %0d", e.quat_w, out_data.quat_w);
            errors++;
          end
          if (out_data.conversion_ok !== e.conversion_ok) begin
            $error("conversion_ok exp %0b got %0b", e.conversion_ok, out_data.conversion_ok);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    in_t m;
    int drain;
    errors = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    in_taken = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_phase = 0;
    stall_period = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
    pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));
    pending_mats.push_back(diag_mat(0, 0, 0, 0));
    pending_mats.push_back(diag_mat(-16384, -16384, -16384, 0));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, 100));
    pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));
    pending_mats.push_back(diag_mat(32767, -32768, -32768, -32768));
    pending_mats.push_back(diag_mat(-8192, -8192, 0, 0));
    pending_mats.push_back(diag_mat(-5462, -5461, -5461, 0));
    pending_mats.push_back(diag_mat(0, 0, 16384, 0));
    pending_mats.push_back(diag_mat(1, 1, 1, 1));
    pending_mats.push_back(diag_mat(-16383, -16384, -16384, 32767));
    m = '1;
    pending_mats.push_back(m);
    m = {9{16'h8000}};
    pending_mats.push_back(m);
    m = {9{16'h7fff}};
    pending_mats.push_back(m);
    m = {9{16'h5555}};
    pending_mats.push_back(m);
    m = {9{16'haaaa}};
    pending_mats.push_back(m);

    wait (pending_mats.size() == 0);
    @(negedge clk);
    hold_sender = 1'b1;
    while (expected_quats.size() != 0 || in_valid) @(posedge clk);
    hold_sender = 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(9) < 7) begin
        m = rand_rotation_like();
      end else begin
        for (int k = 0; k < 9; k++) m[k*16 +: 16] = 16'($urandom());
      end
      pending_mats.push_back(m);
    end

    fork
      begin
        wait (pending_mats.size() == 0 && !in_valid && expected_quats.size() == 0);
        drain = 0;
        while (drain < LATENCY * 4) begin
          @(posedge clk);
          drain++;
        end
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    join_any

    if (errors == 0 && expected_quats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
